[design/hfc_pkg.sv]
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the humidity/temperature frame checker.
// ----------------------------------------------------------------------------
package hfc_pkg;

    // frame layout: six data bytes followed by one CRC byte
    localparam int FRAME_BYTES = 7;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

    // CRC-8, MSB first
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] BUSY_MASK = 8'h80;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 20;
    localparam int HUM_W   = 10;
    localparam int TEMP_W  = 12;
    localparam int TIMER_W = 8;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // scaling to tenths
    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic [11:0] TEMP_OFFSET = 12'd500;

    // configuration reset values
    localparam logic [TIMER_W-1:0] LINK_RELOAD_RST = 8'd10;
    localparam logic [RAW_W-1:0]   FS_THRESH_RST   = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] FS_CONFIRM_RST  = 8'd3;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } t_op;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_FRAME = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_UPDATED   = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_BUSY      = 2'd2,
        ST_FULLSCALE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_RELOAD = 2'd0,
        REG_FS_THRESH   = 2'd1,
        REG_FS_CONFIRM  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TIMER_W-1:0] link_timeout_reload;
        logic [RAW_W-1:0]   fullscale_threshold;
        logic [COUNT_W-1:0] fullscale_confirm_count;
    } t_cfg;

    typedef struct packed {
        logic                     event_kind;
        logic [1:0]               frame_status;
        logic [HUM_W-1:0]         humidity_x10;
        logic signed [TEMP_W-1:0] temperature_x10;
        logic                     data_valid;
        logic                     sensor_error;
    } t_result;

endpackage

[design/hfc_if.sv]
// ----------------------------------------------------------------------------
// hfc_if
// Valid/ready channels of the frame checker: input words, result words and
// configuration writes.
// ----------------------------------------------------------------------------
interface hfc_in_if;
    import hfc_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface hfc_out_if;
    import hfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     event_kind;
    logic [1:0]               frame_status;
    logic [HUM_W-1:0]         humidity_x10;
    logic signed [TEMP_W-1:0] temperature_x10;
    logic                     data_valid;
    logic                     sensor_error;

    modport source (output valid, output event_kind, output frame_status,
                    output humidity_x10, output temperature_x10,
                    output data_valid, output sensor_error, input ready);
    modport sink   (input valid, input event_kind, input frame_status,
                    input humidity_x10, input temperature_x10,
                    input data_valid, input sensor_error, output ready);
endinterface

interface hfc_cfg_if;
    import hfc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/hfc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hfc_cfg_regs
// Configuration register file: link timeout reload, full-scale threshold and
// full-scale confirmation count.
// ----------------------------------------------------------------------------
module hfc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hfc_cfg_if.sink       i_cfg,
    output hfc_pkg::t_cfg o_cfg
);
    import hfc_pkg::*;

    t_cfg r_cfg;

    // every write is taken at once
    assign i_cfg.ready = 1'b1;

    // load the addressed register, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_reload     <= LINK_RELOAD_RST;
            r_cfg.fullscale_threshold     <= FS_THRESH_RST;
            r_cfg.fullscale_confirm_count <= FS_CONFIRM_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LINK_RELOAD: begin
                    r_cfg.link_timeout_reload <= i_cfg.data[TIMER_W-1:0];
                end
                REG_FS_THRESH: begin
                    r_cfg.fullscale_threshold <= i_cfg.data[RAW_W-1:0];
                end
                REG_FS_CONFIRM: begin
                    r_cfg.fullscale_confirm_count <= i_cfg.data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/hfc_frame_core.sv]
// ----------------------------------------------------------------------------
// hfc_frame_core
// Frame state and single-pass evaluation: CRC accumulation, byte store, link
// timer, full-scale confirmation and scaling of the published measurement.
// ----------------------------------------------------------------------------
module hfc_frame_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hfc_pkg::t_cfg                 i_cfg,
    input  logic                          i_fire,
    input  logic                          i_op,
    input  logic [hfc_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_emit,
    output hfc_pkg::t_result              o_result
);
    import hfc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] DONE_IDX = IDX_W'(FRAME_BYTES);

    // one CRC-8 byte update, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [IDX_W-1:0]         r_byte_index, n_byte_index;
    logic [7:0]               r_crc, n_crc;
    logic [BYTE_W-1:0]        r_store [STORE_DEPTH];
    logic [TIMER_W-1:0]       r_link_timer, n_link_timer;
    logic [COUNT_W-1:0]       r_fs_count, n_fs_count;
    logic                     r_error, n_error;
    logic                     r_valid, n_valid;
    logic [HUM_W-1:0]         r_hum, n_hum;
    logic [TEMP_W-1:0]        r_temp, n_temp;

    logic [RAW_W-1:0]         raw_h;
    logic [RAW_W-1:0]         raw_t;
    logic [RAW_W+HUM_W-1:0]   hum_prod;
    logic [RAW_W+11-1:0]      temp_prod;
    logic [TEMP_W-1:0]        temp_scaled;
    logic [COUNT_W-1:0]       fs_inc;
    logic                     store_wr;
    logic                     emit;
    logic                     kind;
    logic [1:0]               status;

    // assemble raw humidity and temperature from the stored bytes
    assign raw_h = {r_store[1], r_store[2], r_store[3][7:4]};
    assign raw_t = {r_store[3][3:0], r_store[4], r_store[5]};

    // scale to tenths
    assign hum_prod    = raw_h * HUM_SCALE;
    assign temp_prod   = raw_t * TEMP_SCALE;
    assign temp_scaled = {1'b0, temp_prod[RAW_W+11-1:RAW_W]} - TEMP_OFFSET;

    // next frame state for the word in the input register
    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_link_timer = r_link_timer;
        n_fs_count   = r_fs_count;
        n_error      = r_error;
        n_valid      = r_valid;
        n_hum        = r_hum;
        n_temp       = r_temp;
        fs_inc       = r_fs_count;
        store_wr     = 1'b0;
        emit         = 1'b0;
        kind         = KIND_TICK;
        status       = ST_UPDATED;

        if (i_op == OP_TICK) begin
            if (r_link_timer != '0) begin
                n_link_timer = r_link_timer - 1'b1;
            end else begin
                n_error = 1'b1;
            end
            n_byte_index = '0;
            n_crc        = CRC_INIT;
            emit         = 1'b1;
        end else if (r_byte_index < LAST_IDX) begin
            store_wr     = 1'b1;
            n_crc        = crc8_byte(r_crc, i_rx_byte);
            n_byte_index = r_byte_index + 1'b1;
        end else if (r_byte_index == LAST_IDX) begin
            n_byte_index = DONE_IDX;
            emit         = 1'b1;
            kind         = KIND_FRAME;
            if (i_rx_byte != r_crc) begin
                n_fs_count = '0;
                status     = ST_CRC_ERR;
            end else if ((r_store[0] & BUSY_MASK) != '0) begin
                n_fs_count = '0;
                status     = ST_BUSY;
            end else begin
                n_link_timer = i_cfg.link_timeout_reload;
                if (raw_h >= i_cfg.fullscale_threshold) begin
                    if (r_fs_count < i_cfg.fullscale_confirm_count) begin
                        fs_inc = r_fs_count + 1'b1;
                    end
                    n_fs_count = fs_inc;
                    if (fs_inc >= i_cfg.fullscale_confirm_count) begin
                        n_error = 1'b1;
                    end
                    status = ST_FULLSCALE;
                end else begin
                    n_fs_count = '0;
                    n_error    = 1'b0;
                    n_valid    = 1'b1;
                    n_hum      = hum_prod[RAW_W+HUM_W-1:RAW_W];
                    n_temp     = temp_scaled;
                    status     = ST_UPDATED;
                end
            end
        end
    end

    // advance control state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= CRC_INIT;
            r_link_timer <= LINK_RELOAD_RST;
            r_fs_count   <= '0;
            r_error      <= 1'b0;
            r_valid      <= 1'b0;
            r_hum        <= '0;
            r_temp       <= '0;
        end else if (i_fire) begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_link_timer <= n_link_timer;
            r_fs_count   <= n_fs_count;
            r_error      <= n_error;
            r_valid      <= n_valid;
            r_hum        <= n_hum;
            r_temp       <= n_temp;
        end
    end

    // capture data bytes of the current frame
    always_ff @(posedge i_clk) begin
        if (i_fire && store_wr) begin
            r_store[r_byte_index[$clog2(STORE_DEPTH)-1:0]] <= i_rx_byte;
        end
    end

    // result carries the state as left by this word
    assign o_emit                   = emit;
    assign o_result.event_kind      = kind;
    assign o_result.frame_status    = status;
    assign o_result.humidity_x10    = n_hum;
    assign o_result.temperature_x10 = n_temp;
    assign o_result.data_valid      = n_valid;
    assign o_result.sensor_error    = n_error;

endmodule

[design/humidity_temp_frame_checker.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Checks CRC-8 of 7-byte humidity/temperature sensor frames, tracks link
// timeout and full-scale faults, and publishes measurements in tenths.
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    op, rx_byte
//   o_result  out   valid/ready    event_kind, frame_status, humidity_x10,
//                                  temperature_x10, data_valid, sensor_error
//   i_cfg     in    valid/ready    index, data (always ready)
//
// One word per cycle while results are taken; a word waits in the input register
// and a processed tick or CRC byte has its result put in the output register.
// The input register refills while the result register waits, so a stalled
// result holds back at most one further word.
// Synchronous active-low reset returns all control state and configuration to
// defaults; the frame byte store holds no reset value.
// ----------------------------------------------------------------------------
module humidity_temp_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hfc_in_if.sink     i_item,
    hfc_out_if.source  o_result,
    hfc_cfg_if.sink    i_cfg
);
    import hfc_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_op;
    logic [BYTE_W-1:0] r_in_byte;
    logic              fire;
    logic              emit;
    t_result           core_res;
    logic              r_out_valid;
    t_result           r_out_res;

    hfc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // process the held word when the result register is free or draining
    assign fire         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op   <= i_item.op;
            r_in_byte <= i_item.rx_byte;
        end
    end

    hfc_frame_core u_frame_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_fire    (fire),
        .i_op      (r_in_op),
        .i_rx_byte (r_in_byte),
        .o_emit    (emit),
        .o_result  (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_res <= core_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.event_kind      = r_out_res.event_kind;
    assign o_result.frame_status    = r_out_res.frame_status;
    assign o_result.humidity_x10    = r_out_res.humidity_x10;
    assign o_result.temperature_x10 = r_out_res.temperature_x10;
    assign o_result.data_valid      = r_out_res.data_valid;
    assign o_result.sensor_error    = r_out_res.sensor_error;

    // a tick always yields a result
    a_tick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_op == OP_TICK |=> r_out_valid)
        else $error("tick produced no result");

    // a published frame clears the error and marks data valid
    a_update_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.event_kind == KIND_FRAME
            && r_out_res.frame_status == ST_UPDATED
        |-> !r_out_res.sensor_error && r_out_res.data_valid)
        else $error("published frame with error or without data valid");

    // data valid never drops between results
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.data_valid && fire && emit |=> r_out_res.data_valid)
        else $error("data valid dropped");

    // empty input register always takes a word
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_item.ready)
        else $error("input stalled while empty");

endmodule

[test/tb_humidity_temp_frame_checker.sv]
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_checker
// Self-checking bench for the sensor frame checker. Sends poll ticks and frame
// bytes (directed corner frames, then random well-formed, truncated and noisy
// traffic across several register settings and idle patterns), predicts every
// status word in a local decoder and compares each one field by field.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import hfc_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned PHASES       = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hfc_in_if  item_if ();
    hfc_out_if result_if ();
    hfc_cfg_if cfg_if ();

    humidity_temp_frame_checker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // bench controls and bookkeeping
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned counted_words  = 0;

    // decoder state mirrored in the bench
    t_cfg               cfg_shadow;
    logic [IDX_W-1:0]   frame_pos;
    logic [BYTE_W-1:0]  frame_crc;
    logic [BYTE_W-1:0]  frame_data [STORE_DEPTH];
    logic [TIMER_W-1:0] link_countdown;
    logic [COUNT_W-1:0] fullscale_run;
    logic               fault_flag;
    logic               published;
    logic [HUM_W-1:0]   humidity_last;
    logic [TEMP_W-1:0]  temperature_last;

    t_result pending_reports [$];

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // one CRC-8 byte step, MSB first
    function automatic logic [BYTE_W-1:0] crc8_step(logic [BYTE_W-1:0] crc,
                                                     logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic t_result status_word(t_kind kind, t_status st);
        t_result r;
        r.event_kind      = kind;
        r.frame_status    = st;
        r.humidity_x10    = humidity_last;
        r.temperature_x10 = temperature_last;
        r.data_valid      = published;
        r.sensor_error    = fault_flag;
        return r;
    endfunction

    task automatic clear_decoder();
        cfg_shadow.link_timeout_reload     = LINK_RELOAD_RST;
        cfg_shadow.fullscale_threshold     = FS_THRESH_RST;
        cfg_shadow.fullscale_confirm_count = FS_CONFIRM_RST;
        frame_pos        = '0;
        frame_crc        = CRC_INIT;
        link_countdown   = LINK_RELOAD_RST;
        fullscale_run    = '0;
        fault_flag       = 1'b0;
        published        = 1'b0;
        humidity_last    = '0;
        temperature_last = '0;
    endtask

    // advance the decoder by one accepted word and queue the status it causes
    task automatic predict_report(input t_op op, input logic [BYTE_W-1:0] b);
        logic [RAW_W-1:0] raw_h;
        logic [RAW_W-1:0] raw_t;
        logic [29:0]      hum_prod;
        logic [30:0]      temp_prod;
        t_status          st;
        if (op == OP_TICK) begin
            if (link_countdown != 0)
                link_countdown--;
            else
                fault_flag = 1'b1;
            frame_pos = '0;
            frame_crc = CRC_INIT;
            counted_words++;
            pending_reports.push_back(status_word(KIND_TICK, ST_UPDATED));
        end else if (frame_pos < STORE_DEPTH) begin
            frame_data[frame_pos] = b;
            frame_crc = crc8_step(frame_crc, b);
            frame_pos++;
            counted_words++;
        end else if (frame_pos == STORE_DEPTH) begin
            frame_pos = IDX_W'(FRAME_BYTES);
            counted_words++;
            if (b != frame_crc) begin
                fullscale_run = '0;
                st = ST_CRC_ERR;
            end else if ((frame_data[0] & BUSY_MASK) != 0) begin
                fullscale_run = '0;
                st = ST_BUSY;
            end else begin
                link_countdown = cfg_shadow.link_timeout_reload;
                raw_h = {frame_data[1], frame_data[2], frame_data[3][7:4]};
                raw_t = {frame_data[3][3:0], frame_data[4], frame_data[5]};
                if (raw_h >= cfg_shadow.fullscale_threshold) begin
                    if (fullscale_run < cfg_shadow.fullscale_confirm_count)
                        fullscale_run++;
                    if (fullscale_run >= cfg_shadow.fullscale_confirm_count)
                        fault_flag = 1'b1;
                    st = ST_FULLSCALE;
                end else begin
                    fullscale_run = '0;
                    fault_flag    = 1'b0;
                    published     = 1'b1;
                    hum_prod      = raw_h * HUM_SCALE;
                    temp_prod     = raw_t * TEMP_SCALE;
                    humidity_last    = hum_prod[29:20];
                    temperature_last = {1'b0, temp_prod[30:20]} - TEMP_OFFSET;
                    st = ST_UPDATED;
                end
            end
            pending_reports.push_back(status_word(KIND_FRAME, st));
        end
    endtask

    // send one word; valid stays high into the next call unless a gap is drawn
    task automatic send_word(input t_op op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.op      <= op;
        item_if.rx_byte <= b;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        predict_report(op, b);
    endtask

    // pack raw readings into six data bytes plus CRC and send them
    task automatic send_frame(input logic [BYTE_W-1:0] status_b,
                              input logic [RAW_W-1:0] raw_h,
                              input logic [RAW_W-1:0] raw_t,
                              input logic bad_crc);
        logic [BYTE_W-1:0] octets [FRAME_BYTES];
        logic [BYTE_W-1:0] crc;
        octets[0] = status_b;
        octets[1] = raw_h[19:12];
        octets[2] = raw_h[11:4];
        octets[3] = {raw_h[3:0], raw_t[19:16]};
        octets[4] = raw_t[15:8];
        octets[5] = raw_t[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < STORE_DEPTH; i++)
            crc = crc8_step(crc, octets[i]);
        octets[STORE_DEPTH] = bad_crc ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
        for (int i = 0; i < FRAME_BYTES; i++)
            send_word(OP_BYTE, octets[i]);
    endtask

    // drop valid, wait for every queued status, then let trailing bytes finish
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            REG_LINK_RELOAD: cfg_shadow.link_timeout_reload     = value[TIMER_W-1:0];
            REG_FS_THRESH:   cfg_shadow.fullscale_threshold     = value[RAW_W-1:0];
            REG_FS_CONFIRM:  cfg_shadow.fullscale_confirm_count = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // write all three registers while the block is idle
    task automatic apply_settings(input logic [TIMER_W-1:0] reload,
                                  input logic [RAW_W-1:0] thresh,
                                  input logic [COUNT_W-1:0] confirm);
        settle();
        write_reg(REG_LINK_RELOAD, CFG_DATA_W'(reload));
        write_reg(REG_FS_THRESH, CFG_DATA_W'(thresh));
        write_reg(REG_FS_CONFIRM, CFG_DATA_W'(confirm));
        cfg_if.valid <= 1'b0;
    endtask

    // frame right after reset with no tick, then a stray byte that is ignored
    task automatic test_start_without_tick();
        apply_settings(8'd1, FS_THRESH_RST, 8'd1);
        send_frame(8'h7F, 20'h00000, 20'h00000, 1'b0);
        send_word(OP_BYTE, 8'hFF);
    endtask

    // timer was reloaded to one: first tick reaches zero, second raises error
    task automatic test_link_timeout();
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'hFF);
    endtask

    // crc mismatch, busy sensor, confirmed full-scale
    task automatic test_frame_faults();
        send_frame(8'h00, 20'h00000, 20'h00000, 1'b1);
        send_word(OP_TICK, 8'h00);
        send_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
        send_word(OP_TICK, 8'h00);
        send_frame(8'h00, 20'hFFFFF, 20'h5A5A5, 1'b0);
    endtask

    // mostly well-formed tick+frame sequences, some truncated frames and noise
    task automatic test_random_frames(input int unsigned phase);
        logic [TIMER_W-1:0] reload;
        logic [RAW_W-1:0]   thresh;
        logic [COUNT_W-1:0] confirm;
        logic [RAW_W-1:0]   raw_h;
        logic [RAW_W-1:0]   raw_t;
        logic [BYTE_W-1:0]  status_b;
        int unsigned        target;
        int unsigned        pick;
        case (phase)
            0: begin reload = 8'd255; thresh = 20'hFFFFF; confirm = 8'd255; end
            1: begin reload = 8'd1;   thresh = 20'h00000; confirm = 8'd0;   end
            2: begin reload = 8'd2;   thresh = 20'h80000; confirm = 8'd3;   end
            3: begin reload = 8'd255; thresh = 20'h00000; confirm = 8'd1;   end
            default: begin
                reload  = TIMER_W'($urandom_range(1, 255));
                thresh  = RAW_W'($urandom_range(0, 20'hFFFFF));
                confirm = COUNT_W'($urandom_range(1, 255));
            end
        endcase
        apply_settings(reload, thresh, confirm);

        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase

        target = counted_words + RANDOM_WORDS / PHASES;
        while (counted_words < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                case ($urandom_range(0, 4))
                    0: raw_h = thresh;
                    1: raw_h = thresh - 1'b1;
                    2: raw_h = 20'hFFFFF;
                    3: raw_h = 20'h00000;
                    default: raw_h = RAW_W'($urandom_range(0, 20'hFFFFF));
                endcase
                case ($urandom_range(0, 3))
                    0: raw_t = 20'h00000;
                    1: raw_t = 20'hFFFFF;
                    default: raw_t = RAW_W'($urandom_range(0, 20'hFFFFF));
                endcase
                status_b    = BYTE_W'($urandom_range(0, 255));
                status_b[7] = ($urandom_range(0, 99) < 15);
                send_word(OP_TICK, BYTE_W'($urandom_range(0, 255)));
                send_frame(status_b, raw_h, raw_t, $urandom_range(0, 99) < 15);
                if ($urandom_range(0, 99) < 20)
                    repeat ($urandom_range(1, 3))
                        send_word(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                send_word(OP_TICK, BYTE_W'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 6))
                    send_word(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(t_op'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each accepted status word with the oldest prediction
    always @(posedge i_clk) begin : check_reports
        t_result want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected status word: event_kind %0d frame_status %0d",
                       result_if.event_kind, result_if.frame_status);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (result_if.event_kind !== want.event_kind) begin
                    $error("event_kind: expected %0d, actual %0d",
                           want.event_kind, result_if.event_kind);
                    error_count++;
                end
                if (result_if.frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, result_if.frame_status);
                    error_count++;
                end
                if (result_if.humidity_x10 !== want.humidity_x10) begin
                    $error("humidity_x10: expected %0d, actual %0d",
                           want.humidity_x10, result_if.humidity_x10);
                    error_count++;
                end
                if (result_if.temperature_x10 !== want.temperature_x10) begin
                    $error("temperature_x10: expected %0d, actual %0d",
                           $signed(want.temperature_x10), $signed(result_if.temperature_x10));
                    error_count++;
                end
                if (result_if.data_valid !== want.data_valid) begin
                    $error("data_valid: expected %0d, actual %0d",
                           want.data_valid, result_if.data_valid);
                    error_count++;
                end
                if (result_if.sensor_error !== want.sensor_error) begin
                    $error("sensor_error: expected %0d, actual %0d",
                           want.sensor_error, result_if.sensor_error);
                    error_count++;
                end
            end
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_humidity_temp_frame_checker: FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        item_if.valid   <= 1'b0;
        item_if.op      <= OP_TICK;
        item_if.rx_byte <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_LINK_RELOAD;
        cfg_if.data     <= '0;
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_without_tick();
        test_link_timeout();
        test_frame_faults();
        for (int unsigned p = 0; p < PHASES; p++)
            test_random_frames(p);
        settle();

        if (error_count == 0)
            $display("tb_humidity_temp_frame_checker: PASS");
        else
            $display("tb_humidity_temp_frame_checker: FAIL");
        $finish;
    end

endmodule

[humidity_temp_frame_checker.f]
design/hfc_pkg.sv
design/hfc_if.sv
design/hfc_cfg_regs.sv
design/hfc_frame_core.sv
design/humidity_temp_frame_checker.sv
test/tb_humidity_temp_frame_checker.sv
